// ===== rtl/ltla_pkg.sv =====
// ============================================================================
// ltla_pkg
// Shared types and constants for the linked timer and LFSR audio unit.
// ============================================================================
package ltla_pkg;

    localparam int TIMER_NUM = 8;

    // Command codes of an input beat.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Unit code that marks the end of a link chain.
    localparam logic [3:0] LINK_NONE = 4'hf;

    // Fixed register offsets.
    localparam logic [7:0] ADDR_PEND_CLR = 8'h80;
    localparam logic [7:0] ADDR_PEND_SET = 8'h81;
    localparam logic [7:0] ADDR_ZERO_A   = 8'h84;
    localparam logic [7:0] ADDR_ZERO_B   = 8'h85;
    localparam logic [7:0] ADDR_CONST_80 = 8'h86;
    localparam logic [7:0] ADDR_CONST_01 = 8'h88;
    localparam logic [7:0] ADDR_DIR      = 8'h8a;
    localparam logic [7:0] ADDR_PORT     = 8'h8b;
    localparam logic [7:0] ADDR_CONST_A0 = 8'h8c;
    localparam logic [7:0] ADDR_ZERO_C   = 8'h8d;
    localparam logic [7:0] ADDR_DISP_LO  = 8'h94;
    localparam logic [7:0] ADDR_DISP_HI  = 8'h95;

    // Scanline values of timer 2 seen at a timer 0 expiry.
    localparam logic [7:0] LINE_VB_SET   = 8'd103;
    localparam logic [7:0] LINE_LATCH    = 8'd102;
    localparam logic [7:0] LINE_VB_CLR   = 8'd101;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_ADD,
        ST_LOOP,
        ST_EXPIRE,
        ST_DONE
    } state_t;

    function automatic logic ctl_linked(input logic [7:0] ctl);
        return ctl[2:0] == 3'd7;
    endfunction

    function automatic logic ctl_count(input logic [7:0] ctl);
        return ctl[3];
    endfunction

    // Prescale period for a clock select, 4 << sel, or 4 for select 7.
    function automatic logic [9:0] scale_of(input logic [2:0] sel);
        logic [9:0] s;
        s = 10'd4 << sel;
        if (sel == 3'd7)
        begin
            s = 10'd4;
        end
        return s;
    endfunction

    // Fixed link partner of each timer; code 8 is audio channel 0.
    function automatic logic [3:0] timer_link(input logic [2:0] t);
        logic [3:0] n;
        case (t)
            3'd0: n = 4'd2;
            3'd1: n = 4'd3;
            3'd2: n = 4'd4;
            3'd3: n = 4'd5;
            3'd5: n = 4'd7;
            3'd7: n = 4'd8;
            default: n = LINK_NONE;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/ltla_cmd_if.sv =====
// ============================================================================
// ltla_cmd_if
// Input channel: one bus read, bus write or tick per beat.
// ============================================================================
interface ltla_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] address;
    logic [7:0] write_data;
    logic [7:0] cycles;

    modport source (output valid, command, address, write_data, cycles, input ready);
    modport sink   (input valid, command, address, write_data, cycles, output ready);
endinterface

// ===== rtl/ltla_res_if.sv =====
// ============================================================================
// ltla_res_if
// Result channel: read data, interrupt level, mixed sample and display base.
// ============================================================================
interface ltla_res_if;
    logic               valid;
    logic               ready;
    logic        [7:0]  read_data;
    logic               irq_level;
    logic signed [15:0] mixed_sample;
    logic        [15:0] display_base;

    modport source (output valid, read_data, irq_level, mixed_sample, display_base,
                    input ready);
    modport sink   (input valid, read_data, irq_level, mixed_sample, display_base,
                    output ready);
endinterface

// ===== rtl/linked_timer_and_lfsr_audio_unit.sv =====
// ============================================================================
// linked_timer_and_lfsr_audio_unit
// Eight linked timers and up to four LFSR audio channels behind a byte bus.
// ============================================================================
// One beat is taken at a time. A read or a write passes its own step and then
// the done state. A tick walks the eight timers and the audio channels in
// order through one shared prescale adder and compare unit. Each unit passes
// an add step; a counting unit has the cycles added there, then counts one
// prescale period per loop step and leaves the loop once less than a period
// remains. Each unit expiring along a link chain adds an expiry step.
// The result register frees the input side, so a new beat is accepted while
// the last result still waits.
module linked_timer_and_lfsr_audio_unit #(
    parameter int AUDIO_NUM = 4
) (
    input  logic     clk,
    input  logic     rst_n,
    ltla_cmd_if.sink   cmd_ch,
    ltla_res_if.source res_ch
);
    import ltla_pkg::*;

    localparam int AW = (AUDIO_NUM > 1) ? $clog2(AUDIO_NUM) : 1;
    localparam logic [3:0] LAST_UNIT = 4'(TIMER_NUM + AUDIO_NUM - 1);

    state_t state_reg, state_next;

    // Latched beat.
    logic [1:0] cmd_reg;
    logic [7:0] addr_reg, wd_reg, cyc_reg;

    // Timer bank.
    logic [7:0] t_rel_reg [TIMER_NUM];
    logic [7:0] t_ctl_reg [TIMER_NUM];
    logic [7:0] t_cnt_reg [TIMER_NUM], t_cnt_next [TIMER_NUM];
    logic [7:0] t_sts_reg [TIMER_NUM], t_sts_next [TIMER_NUM];
    logic [9:0] t_acc_reg [TIMER_NUM], t_acc_next [TIMER_NUM];
    logic [7:0] t_rel_next [TIMER_NUM], t_ctl_next [TIMER_NUM];

    // Audio channels.
    logic [7:0]  a_vol_reg [AUDIO_NUM], a_vol_next [AUDIO_NUM];
    logic [7:0]  a_tap_reg [AUDIO_NUM], a_tap_next [AUDIO_NUM];
    logic [7:0]  a_out_reg [AUDIO_NUM], a_out_next [AUDIO_NUM];
    logic [11:0] a_sh_reg  [AUDIO_NUM], a_sh_next  [AUDIO_NUM];
    logic [7:0]  a_rel_reg [AUDIO_NUM], a_rel_next [AUDIO_NUM];
    logic [7:0]  a_ctl_reg [AUDIO_NUM], a_ctl_next [AUDIO_NUM];
    logic [7:0]  a_cnt_reg [AUDIO_NUM], a_cnt_next [AUDIO_NUM];
    logic [7:0]  a_ext_reg [AUDIO_NUM], a_ext_next [AUDIO_NUM];
    logic [9:0]  a_acc_reg [AUDIO_NUM], a_acc_next [AUDIO_NUM];

    logic [7:0]  pend_reg, pend_next;
    logic [15:0] disp_reg, disp_next;
    logic        vb_reg, vb_next;

    // Shadows of general registers that feed logic directly.
    logic [7:0] dir_reg, dir_next, port_reg, port_next;
    logic [7:0] dlo_reg, dlo_next, dhi_reg, dhi_next;

    // General register memory with per-entry valid bits.
    logic [7:0]   gr_mem [256];
    logic [255:0] gr_vld_reg;
    logic [7:0]   gr_rd_reg;
    logic         gr_rd_vld_reg;
    logic         mem_we;

    // Sequencer indexes.
    logic [3:0] u_reg, u_next, w_reg, w_next;
    logic [7:0] rd_reg, rd_next;

    // Result register.
    logic               out_valid_reg;
    logic [7:0]         out_rd_reg;
    logic               out_irq_reg;
    logic signed [15:0] out_mix_reg;
    logic [15:0]        out_disp_reg;
    logic               load;

    logic signed [15:0] mix;

    assign cmd_ch.ready = (state_reg == ST_IDLE);
    assign res_ch.valid        = out_valid_reg;
    assign res_ch.read_data    = out_rd_reg;
    assign res_ch.irq_level    = out_irq_reg;
    assign res_ch.mixed_sample = out_mix_reg;
    assign res_ch.display_base = out_disp_reg;

    assign load = (state_reg == ST_DONE) && (!out_valid_reg || res_ch.ready);

    // Mixed sample: signed channel outputs summed and scaled by 64.
    always_comb
    begin
        mix = '0;
        for (int c = 0; c < AUDIO_NUM; c++)
        begin
            mix = mix + ({{8{a_out_reg[c][7]}}, a_out_reg[c]} <<< 6);
        end
    end

    // General register memory: write from the write step, read at the bus address.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            gr_mem[addr_reg] <= wd_reg;
        end
        gr_rd_reg     <= gr_mem[cmd_ch.address];
        gr_rd_vld_reg <= gr_vld_reg[cmd_ch.address];
    end

    // Sequencer and all state updates.
    always_comb
    begin
        logic [2:0]    ti;
        logic [AW-1:0] ai, ni;
        logic          is_a;
        logic [7:0]    ctl_u, cnt_u;
        logic [9:0]    acc_u, sc_u;
        logic          elig;
        logic [3:0]    nx;
        logic [11:0]   sh;
        logic          par;
        logic [AW+1:0] ac;
        logic [7:0]    pv;

        state_next = state_reg;
        u_next = u_reg;
        w_next = w_reg;
        rd_next = rd_reg;
        t_rel_next = t_rel_reg; t_ctl_next = t_ctl_reg; t_cnt_next = t_cnt_reg;
        t_sts_next = t_sts_reg; t_acc_next = t_acc_reg;
        a_vol_next = a_vol_reg; a_tap_next = a_tap_reg; a_out_next = a_out_reg;
        a_sh_next = a_sh_reg; a_rel_next = a_rel_reg; a_ctl_next = a_ctl_reg;
        a_cnt_next = a_cnt_reg; a_ext_next = a_ext_reg; a_acc_next = a_acc_reg;
        pend_next = pend_reg; disp_next = disp_reg; vb_next = vb_reg;
        dir_next = dir_reg; port_next = port_reg; dlo_next = dlo_reg; dhi_next = dhi_reg;
        mem_we = 1'b0;

        // Fields of the unit under the prescale walk.
        ti = u_reg[2:0];
        ai = u_reg[AW-1:0];
        is_a = u_reg[3];
        ctl_u = is_a ? a_ctl_reg[ai] : t_ctl_reg[ti];
        cnt_u = is_a ? a_cnt_reg[ai] : t_cnt_reg[ti];
        acc_u = is_a ? a_acc_reg[ai] : t_acc_reg[ti];
        sc_u  = scale_of(ctl_u[2:0]);
        elig  = ctl_count(ctl_u) && !ctl_linked(ctl_u) &&
                !(is_a ? a_ext_reg[ai][3] : t_sts_reg[ti][3]);
        nx = LINK_NONE;
        sh = '0;
        par = 1'b0;
        ni = '0;
        ac = addr_reg[AW+4:3];
        pv = 8'h04;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_ch.valid)
                begin
                    rd_next = '0;
                    u_next = '0;
                    case (cmd_ch.command)
                        CMD_READ:  state_next = ST_READ;
                        CMD_WRITE: state_next = ST_WRITE;
                        CMD_TICK:  state_next = ST_ADD;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end

            // Read data is chosen once the memory word is back.
            ST_READ:
            begin
                if (addr_reg < 8'h20)
                begin
                    case (addr_reg[1:0])
                        2'd0:    rd_next = t_rel_reg[addr_reg[4:2]];
                        2'd1:    rd_next = t_ctl_reg[addr_reg[4:2]];
                        2'd2:    rd_next = t_cnt_reg[addr_reg[4:2]];
                        default: rd_next = t_sts_reg[addr_reg[4:2]];
                    endcase
                end
                else if (addr_reg < 8'h40)
                begin
                    if (int'({1'b0, addr_reg[4:3]}) >= AUDIO_NUM)
                    begin
                        rd_next = '0;
                    end
                    else
                    begin
                        case (addr_reg[2:0])
                            3'd0:    rd_next = a_vol_reg[ac[AW-1:0]];
                            3'd1:    rd_next = a_tap_reg[ac[AW-1:0]];
                            3'd2:    rd_next = a_out_reg[ac[AW-1:0]];
                            3'd3:    rd_next = a_sh_reg[ac[AW-1:0]][7:0];
                            3'd4:    rd_next = a_rel_reg[ac[AW-1:0]];
                            3'd5:    rd_next = a_ctl_reg[ac[AW-1:0]];
                            3'd6:    rd_next = a_cnt_reg[ac[AW-1:0]];
                            default: rd_next = {a_ext_reg[ac[AW-1:0]][7:4],
                                                a_sh_reg[ac[AW-1:0]][11:8]};
                        endcase
                    end
                end
                else
                begin
                    case (addr_reg)
                        ADDR_PEND_CLR, ADDR_PEND_SET: rd_next = pend_reg;
                        ADDR_ZERO_A, ADDR_ZERO_B, ADDR_ZERO_C: rd_next = 8'h00;
                        ADDR_CONST_80: rd_next = 8'h80;
                        ADDR_CONST_01: rd_next = 8'h01;
                        ADDR_CONST_A0: rd_next = 8'ha0;
                        ADDR_PORT:
                        begin
                            pv[0] = dir_reg[0] ? port_reg[0] : 1'b1;
                            pv[1] = dir_reg[1] ? port_reg[1] : 1'b0;
                            pv[3] = dir_reg[3] && !(port_reg[3] && vb_reg);
                            pv[4] = dir_reg[4] ? port_reg[4] : 1'b1;
                            rd_next = pv;
                        end
                        default: rd_next = gr_rd_vld_reg ? gr_rd_reg : 8'h00;
                    endcase
                end
                state_next = ST_DONE;
            end

            ST_WRITE:
            begin
                if (addr_reg < 8'h20)
                begin
                    case (addr_reg[1:0])
                        2'd0: t_rel_next[addr_reg[4:2]] = wd_reg;
                        2'd1:
                        begin
                            t_ctl_next[addr_reg[4:2]] = wd_reg;
                            if (wd_reg[6])
                            begin
                                t_sts_next[addr_reg[4:2]][3] = 1'b0;
                            end
                            if (ctl_count(wd_reg) && t_cnt_reg[addr_reg[4:2]] == 8'd0)
                            begin
                                t_cnt_next[addr_reg[4:2]] = t_rel_reg[addr_reg[4:2]];
                            end
                            t_acc_next[addr_reg[4:2]] = '0;
                        end
                        2'd2: t_cnt_next[addr_reg[4:2]] = wd_reg;
                        default: t_sts_next[addr_reg[4:2]][3] = wd_reg[3];
                    endcase
                end
                else
                begin
                    if (addr_reg == ADDR_PEND_CLR)
                    begin
                        pend_next = pend_reg & ~wd_reg;
                    end
                    else if (addr_reg == ADDR_PEND_SET)
                    begin
                        pend_next = pend_reg | wd_reg;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (addr_reg == ADDR_DIR)     dir_next = wd_reg;
                        if (addr_reg == ADDR_PORT)    port_next = wd_reg;
                        if (addr_reg == ADDR_DISP_LO) dlo_next = wd_reg;
                        if (addr_reg == ADDR_DISP_HI) dhi_next = wd_reg;
                    end
                    if (addr_reg < 8'h40 && int'({1'b0, addr_reg[4:3]}) < AUDIO_NUM)
                    begin
                        case (addr_reg[2:0])
                            3'd0: a_vol_next[ac[AW-1:0]] = wd_reg;
                            3'd1: a_tap_next[ac[AW-1:0]] = wd_reg;
                            3'd2: a_out_next[ac[AW-1:0]] = wd_reg;
                            3'd3: a_sh_next[ac[AW-1:0]][7:0] = wd_reg;
                            3'd4: a_rel_next[ac[AW-1:0]] = wd_reg;
                            3'd5:
                            begin
                                a_ctl_next[ac[AW-1:0]] = wd_reg;
                                if (wd_reg[6])
                                begin
                                    a_ext_next[ac[AW-1:0]][3] = 1'b0;
                                end
                                a_acc_next[ac[AW-1:0]] = '0;
                            end
                            3'd6: a_cnt_next[ac[AW-1:0]] = wd_reg;
                            default:
                            begin
                                a_ext_next[ac[AW-1:0]] = wd_reg;
                                a_sh_next[ac[AW-1:0]][11:8] = wd_reg[3:0];
                            end
                        endcase
                    end
                end
                state_next = ST_DONE;
            end

            // Add the elapsed cycles to the next free-running unit.
            ST_ADD:
            begin
                if (u_reg > LAST_UNIT)
                begin
                    state_next = ST_DONE;
                end
                else if (elig)
                begin
                    if (is_a) a_acc_next[ai] = acc_u + {2'b00, cyc_reg};
                    else      t_acc_next[ti] = acc_u + {2'b00, cyc_reg};
                    state_next = ST_LOOP;
                end
                else
                begin
                    u_next = u_reg + 4'd1;
                end
            end

            // One prescale period per cycle while no expiry chain runs: count down or start an expiry chain.
            ST_LOOP:
            begin
                if (acc_u >= sc_u)
                begin
                    if (is_a) a_acc_next[ai] = acc_u - sc_u;
                    else      t_acc_next[ti] = acc_u - sc_u;
                    if (cnt_u != 8'd0)
                    begin
                        if (is_a) a_cnt_next[ai] = cnt_u - 8'd1;
                        else      t_cnt_next[ti] = cnt_u - 8'd1;
                    end
                    else
                    begin
                        w_next = u_reg;
                        state_next = ST_EXPIRE;
                    end
                end
                else
                begin
                    u_next = u_reg + 4'd1;
                    state_next = ST_ADD;
                end
            end

            // Expire one unit, then follow its link one step.
            ST_EXPIRE:
            begin
                state_next = ST_LOOP;
                if (!w_reg[3])
                begin
                    if (t_ctl_reg[w_reg[2:0]][7] && w_reg[2:0] != 3'd4)
                    begin
                        pend_next[w_reg[2:0]] = 1'b1;
                    end
                    if (w_reg[2:0] == 3'd0)
                    begin
                        if (t_cnt_reg[2] == LINE_VB_SET) vb_next = 1'b1;
                        if (t_cnt_reg[2] == LINE_LATCH)  disp_next = {dhi_reg, dlo_reg};
                        if (t_cnt_reg[2] == LINE_VB_CLR) vb_next = 1'b0;
                    end
                    if (t_ctl_reg[w_reg[2:0]][4])
                    begin
                        t_cnt_next[w_reg[2:0]] = t_rel_reg[w_reg[2:0]];
                    end
                    else
                    begin
                        t_sts_next[w_reg[2:0]][3] = 1'b1;
                    end
                    nx = timer_link(w_reg[2:0]);
                    if (nx == 4'd8)
                    begin
                        if (ctl_count(a_ctl_reg[0]) && ctl_linked(a_ctl_reg[0]) &&
                            !a_ext_reg[0][3])
                        begin
                            if (a_cnt_reg[0] != 8'd0)
                            begin
                                a_cnt_next[0] = a_cnt_reg[0] - 8'd1;
                            end
                            else
                            begin
                                w_next = nx;
                                state_next = ST_EXPIRE;
                            end
                        end
                    end
                    else if (nx != LINK_NONE)
                    begin
                        if (ctl_count(t_ctl_reg[nx[2:0]]) && ctl_linked(t_ctl_reg[nx[2:0]]) &&
                            !t_sts_reg[nx[2:0]][3])
                        begin
                            if (t_cnt_reg[nx[2:0]] != 8'd0)
                            begin
                                t_cnt_next[nx[2:0]] = t_cnt_reg[nx[2:0]] - 8'd1;
                            end
                            else
                            begin
                                w_next = nx;
                                state_next = ST_EXPIRE;
                            end
                        end
                    end
                end
                else
                begin
                    // Audio channel: step the LFSR and drive +/- volume.
                    sh  = a_sh_reg[w_reg[AW-1:0]];
                    par = ^(sh & {a_ext_reg[w_reg[AW-1:0]][3:0], a_tap_reg[w_reg[AW-1:0]]});
                    a_sh_next[w_reg[AW-1:0]] = {par, sh[11:1]};
                    a_out_next[w_reg[AW-1:0]] = sh[0] ? a_vol_reg[w_reg[AW-1:0]]
                                                      : 8'd0 - a_vol_reg[w_reg[AW-1:0]];
                    if (a_ctl_reg[w_reg[AW-1:0]][4])
                    begin
                        a_cnt_next[w_reg[AW-1:0]] = a_rel_reg[w_reg[AW-1:0]];
                    end
                    else
                    begin
                        a_ext_next[w_reg[AW-1:0]][3] = 1'b1;
                    end
                    if (int'(w_reg[AW-1:0]) + 1 < AUDIO_NUM)
                    begin
                        ni = w_reg[AW-1:0] + 1'b1;
                        if (ctl_count(a_ctl_reg[ni]) && ctl_linked(a_ctl_reg[ni]) &&
                            !a_ext_reg[ni][3])
                        begin
                            if (a_cnt_reg[ni] != 8'd0)
                            begin
                                a_cnt_next[ni] = a_cnt_reg[ni] - 8'd1;
                            end
                            else
                            begin
                                w_next = w_reg + 4'd1;
                                state_next = ST_EXPIRE;
                            end
                        end
                    end
                end
            end

            ST_DONE:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Beat capture.
    always_ff @(posedge clk)
    begin
        if (cmd_ch.valid && cmd_ch.ready)
        begin
            cmd_reg  <= cmd_ch.command;
            addr_reg <= cmd_ch.address;
            wd_reg   <= cmd_ch.write_data;
            cyc_reg  <= cmd_ch.cycles;
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            u_reg <= '0;
            w_reg <= '0;
            rd_reg <= '0;
            for (int t = 0; t < TIMER_NUM; t++)
            begin
                t_rel_reg[t] <= '0; t_ctl_reg[t] <= '0; t_cnt_reg[t] <= '0;
                t_sts_reg[t] <= '0; t_acc_reg[t] <= '0;
            end
            for (int c = 0; c < AUDIO_NUM; c++)
            begin
                a_vol_reg[c] <= '0; a_tap_reg[c] <= '0; a_out_reg[c] <= '0;
                a_sh_reg[c] <= 12'd1; a_rel_reg[c] <= '0; a_ctl_reg[c] <= '0;
                a_cnt_reg[c] <= '0; a_ext_reg[c] <= '0; a_acc_reg[c] <= '0;
            end
            pend_reg <= '0;
            disp_reg <= '0;
            vb_reg <= 1'b0;
            dir_reg <= '0; port_reg <= '0; dlo_reg <= '0; dhi_reg <= '0;
            gr_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            u_reg <= u_next;
            w_reg <= w_next;
            rd_reg <= rd_next;
            t_rel_reg <= t_rel_next; t_ctl_reg <= t_ctl_next; t_cnt_reg <= t_cnt_next;
            t_sts_reg <= t_sts_next; t_acc_reg <= t_acc_next;
            a_vol_reg <= a_vol_next; a_tap_reg <= a_tap_next; a_out_reg <= a_out_next;
            a_sh_reg <= a_sh_next; a_rel_reg <= a_rel_next; a_ctl_reg <= a_ctl_next;
            a_cnt_reg <= a_cnt_next; a_ext_reg <= a_ext_next; a_acc_reg <= a_acc_next;
            pend_reg <= pend_next;
            disp_reg <= disp_next;
            vb_reg <= vb_next;
            dir_reg <= dir_next; port_reg <= port_next;
            dlo_reg <= dlo_next; dhi_reg <= dhi_next;
            if (mem_we)
            begin
                gr_vld_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_rd_reg   <= (cmd_reg == CMD_READ) ? rd_reg : 8'h00;
            out_irq_reg  <= (pend_reg != 8'h00);
            out_mix_reg  <= mix;
            out_disp_reg <= disp_reg;
        end
    end

    // Checks on the sequencer.
    a_expire_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXPIRE |-> w_reg <= LAST_UNIT)
        else $error("expiry walker beyond last unit");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOP |-> u_reg <= LAST_UNIT)
        else $error("prescale walk beyond last unit");

    a_irq_matches: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> res_ch.irq_level == (pend_reg != 8'h00))
        else $error("irq level does not follow pending bits");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> cmd_ch.ready && res_ch.valid)
        else $error("result load did not return to idle");

endmodule

// ===== dv/ltla_checker.sv =====
// ============================================================================
// ltla_checker
// Watches both channels of the linked timer and LFSR audio unit. Every
// accepted command beat is run through a local model of the timers, the
// audio channels and the register map. Each result beat is compared field by
// field with the oldest prediction.
// ============================================================================
module ltla_checker (
    input  logic        clk,
    input  logic        rst_n,
    ltla_cmd_if         cmd_ch,
    ltla_res_if         res_ch,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import ltla_pkg::*;

    localparam int AUDIO_NUM = 4;
    localparam int LINK_AUDIO0 = 8;

    typedef struct packed {
        logic        [7:0]  read_data;
        logic               irq_level;
        logic signed [15:0] mixed_sample;
        logic        [15:0] display_base;
    } unit_result_t;

    unit_result_t unit_results_q[$];

    // Local copy of the unit state.
    logic [7:0]  tmr_reload [TIMER_NUM];
    logic [7:0]  tmr_ctl    [TIMER_NUM];
    logic [7:0]  tmr_count  [TIMER_NUM];
    logic [7:0]  tmr_status [TIMER_NUM];
    int          tmr_accum  [TIMER_NUM];
    logic [7:0]  aud_volume [AUDIO_NUM];
    logic [7:0]  aud_taps   [AUDIO_NUM];
    logic [7:0]  aud_out    [AUDIO_NUM];
    logic [11:0] aud_shift  [AUDIO_NUM];
    logic [7:0]  aud_reload [AUDIO_NUM];
    logic [7:0]  aud_ctl    [AUDIO_NUM];
    logic [7:0]  aud_count  [AUDIO_NUM];
    logic [7:0]  aud_extra  [AUDIO_NUM];
    int          aud_accum  [AUDIO_NUM];
    logic [7:0]  irq_pending;
    logic [15:0] disp_start;
    logic        vblank_flag;
    logic [7:0]  gen_regs   [256];

    function automatic int period_of(input logic [2:0] sel);
        return (sel == 3'd7) ? 4 : (4 << sel);
    endfunction

    // Partner of each timer along the cascade; -1 ends the chain.
    function automatic int cascade_next(input int t);
        case (t)
            0: return 2;
            1: return 3;
            2: return 4;
            3: return 5;
            5: return 7;
            7: return LINK_AUDIO0;
            default: return -1;
        endcase
    endfunction

    function automatic logic tmr_linked_ready(input int t);
        return tmr_ctl[t][3] && (tmr_ctl[t][2:0] == 3'd7) && !tmr_status[t][3];
    endfunction

    function automatic logic aud_linked_ready(input int c);
        return aud_ctl[c][3] && (aud_ctl[c][2:0] == 3'd7) && !aud_extra[c][3];
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < TIMER_NUM; i++)
        begin
            tmr_reload[i] = '0;
            tmr_ctl[i] = '0;
            tmr_count[i] = '0;
            tmr_status[i] = '0;
            tmr_accum[i] = 0;
        end
        for (int i = 0; i < AUDIO_NUM; i++)
        begin
            aud_volume[i] = '0;
            aud_taps[i] = '0;
            aud_out[i] = '0;
            aud_shift[i] = 12'd1;
            aud_reload[i] = '0;
            aud_ctl[i] = '0;
            aud_count[i] = '0;
            aud_extra[i] = '0;
            aud_accum[i] = 0;
        end
        for (int i = 0; i < 256; i++)
        begin
            gen_regs[i] = '0;
        end
        gen_regs[ADDR_CONST_01] = 8'd1;
        irq_pending = '0;
        disp_start = '0;
        vblank_flag = 1'b0;
    endfunction

    // Step the LFSR of a channel, rippling into the following channels.
    function automatic void clock_lfsr(input int start);
        int c;
        logic [11:0] sh;
        logic [11:0] mask;
        c = start;
        forever
        begin
            sh = aud_shift[c];
            mask = sh & {aud_extra[c][3:0], aud_taps[c]};
            aud_shift[c] = {^mask, sh[11:1]};
            aud_out[c] = sh[0] ? aud_volume[c] : 8'(-aud_volume[c]);
            if (aud_ctl[c][4])
                aud_count[c] = aud_reload[c];
            else
                aud_extra[c][3] = 1'b1;
            if (c + 1 >= AUDIO_NUM)
                return;
            c++;
            if (!aud_linked_ready(c))
                return;
            if (aud_count[c] > 0)
            begin
                aud_count[c]--;
                return;
            end
        end
    endfunction

    // Expire a timer and follow the cascade as far as it goes.
    function automatic void run_expiry_chain(input int start);
        int w;
        int nx;
        w = start;
        forever
        begin
            if (tmr_ctl[w][7] && w != 4)
                irq_pending[w] = 1'b1;
            if (w == 0)
            begin
                if (tmr_count[2] == LINE_VB_SET)
                    vblank_flag = 1'b1;
                if (tmr_count[2] == LINE_LATCH)
                    disp_start = {gen_regs[ADDR_DISP_HI], gen_regs[ADDR_DISP_LO]};
                if (tmr_count[2] == LINE_VB_CLR)
                    vblank_flag = 1'b0;
            end
            if (tmr_ctl[w][4])
                tmr_count[w] = tmr_reload[w];
            else
                tmr_status[w][3] = 1'b1;
            nx = cascade_next(w);
            if (nx < 0)
                return;
            if (nx == LINK_AUDIO0)
            begin
                if (aud_linked_ready(0))
                begin
                    if (aud_count[0] > 0)
                        aud_count[0]--;
                    else
                        clock_lfsr(0);
                end
                return;
            end
            w = nx;
            if (!tmr_linked_ready(w))
                return;
            if (tmr_count[w] > 0)
            begin
                tmr_count[w]--;
                return;
            end
        end
    endfunction

    function automatic logic [7:0] read_reg(input logic [7:0] a);
        int t;
        int c;
        logic [7:0] dir;
        logic [7:0] d;
        logic [7:0] v;
        if (a < 8'h20)
        begin
            t = a >> 2;
            case (a[1:0])
                2'd0: return tmr_reload[t];
                2'd1: return tmr_ctl[t];
                2'd2: return tmr_count[t];
                default: return tmr_status[t];
            endcase
        end
        if (a < 8'h40)
        begin
            c = (a - 8'h20) >> 3;
            if (c >= AUDIO_NUM)
                return 8'h00;
            case (a[2:0])
                3'd0: return aud_volume[c];
                3'd1: return aud_taps[c];
                3'd2: return aud_out[c];
                3'd3: return aud_shift[c][7:0];
                3'd4: return aud_reload[c];
                3'd5: return aud_ctl[c];
                3'd6: return aud_count[c];
                default: return {aud_extra[c][7:4], aud_shift[c][11:8]};
            endcase
        end
        case (a)
            ADDR_PEND_CLR, ADDR_PEND_SET: return irq_pending;
            ADDR_ZERO_A, ADDR_ZERO_B, ADDR_ZERO_C: return 8'h00;
            ADDR_CONST_80: return 8'h80;
            ADDR_CONST_01: return 8'h01;
            ADDR_CONST_A0: return 8'ha0;
            ADDR_PORT:
            begin
                dir = gen_regs[ADDR_DIR];
                d = gen_regs[ADDR_PORT];
                v = 8'h04;
                v[0] = dir[0] ? d[0] : 1'b1;
                v[1] = dir[1] ? d[1] : 1'b0;
                if (dir[3])
                    v[3] = !(d[3] && vblank_flag);
                v[4] = dir[4] ? d[4] : 1'b1;
                return v;
            end
            default: return gen_regs[a];
        endcase
    endfunction

    function automatic void write_reg(input logic [7:0] a, input logic [7:0] v);
        int t;
        int c;
        if (a < 8'h20)
        begin
            t = a >> 2;
            case (a[1:0])
                2'd0: tmr_reload[t] = v;
                2'd1:
                begin
                    tmr_ctl[t] = v;
                    if (v[6])
                        tmr_status[t][3] = 1'b0;
                    if (v[3] && tmr_count[t] == 0)
                        tmr_count[t] = tmr_reload[t];
                    tmr_accum[t] = 0;
                end
                2'd2: tmr_count[t] = v;
                default: tmr_status[t][3] = v[3];
            endcase
            return;
        end
        if (a < 8'h40)
        begin
            c = (a - 8'h20) >> 3;
            gen_regs[a] = v;
            if (c >= AUDIO_NUM)
                return;
            case (a[2:0])
                3'd0: aud_volume[c] = v;
                3'd1: aud_taps[c] = v;
                3'd2: aud_out[c] = v;
                3'd3: aud_shift[c][7:0] = v;
                3'd4: aud_reload[c] = v;
                3'd5:
                begin
                    aud_ctl[c] = v;
                    if (v[6])
                        aud_extra[c][3] = 1'b0;
                    aud_accum[c] = 0;
                end
                3'd6: aud_count[c] = v;
                default:
                begin
                    aud_extra[c] = v;
                    aud_shift[c][11:8] = v[3:0];
                end
            endcase
            return;
        end
        if (a == ADDR_PEND_CLR)
            irq_pending = irq_pending & ~v;
        else if (a == ADDR_PEND_SET)
            irq_pending = irq_pending | v;
        else
            gen_regs[a] = v;
    endfunction

    function automatic void run_cycles(input int cyc);
        int per;
        for (int i = 0; i < TIMER_NUM; i++)
        begin
            if (!tmr_ctl[i][3] || tmr_ctl[i][2:0] == 3'd7 || tmr_status[i][3])
                continue;
            per = period_of(tmr_ctl[i][2:0]);
            tmr_accum[i] += cyc;
            while (tmr_accum[i] >= per)
            begin
                tmr_accum[i] -= per;
                if (tmr_count[i] > 0)
                    tmr_count[i]--;
                else
                    run_expiry_chain(i);
            end
        end
        for (int i = 0; i < AUDIO_NUM; i++)
        begin
            if (!aud_ctl[i][3] || aud_ctl[i][2:0] == 3'd7 || aud_extra[i][3])
                continue;
            per = period_of(aud_ctl[i][2:0]);
            aud_accum[i] += cyc;
            while (aud_accum[i] >= per)
            begin
                aud_accum[i] -= per;
                if (aud_count[i] > 0)
                    aud_count[i]--;
                else
                    clock_lfsr(i);
            end
        end
    endfunction

    // Apply one command to the model and form the result it produces.
    function automatic unit_result_t predict_unit_result(input logic [1:0] cmd,
                                                         input logic [7:0] addr,
                                                         input logic [7:0] wdata,
                                                         input logic [7:0] cyc);
        unit_result_t r;
        int mix;
        r.read_data = '0;
        if (cmd == CMD_READ)
            r.read_data = read_reg(addr);
        else if (cmd == CMD_WRITE)
            write_reg(addr, wdata);
        else if (cmd == CMD_TICK)
            run_cycles(int'(cyc));
        mix = 0;
        for (int c = 0; c < AUDIO_NUM; c++)
        begin
            mix += int'($signed(aud_out[c])) * 64;
        end
        if (mix > 32767)
            mix = 32767;
        if (mix < -32768)
            mix = -32768;
        r.irq_level = (irq_pending != 0);
        r.mixed_sample = 16'(mix);
        r.display_base = disp_start;
        return r;
    endfunction

    // Compare result beats first, then queue the prediction of a new command.
    always @(posedge clk or negedge rst_n)
    begin
        unit_result_t e;
        int errs;
        if (!rst_n)
        begin
            reset_model();
            unit_results_q.delete();
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (res_ch.valid && res_ch.ready)
            begin
                if (unit_results_q.size() == 0)
                begin
                    $error("result beat with no prediction waiting");
                    errs++;
                end
                else
                begin
                    e = unit_results_q.pop_front();
                    if (res_ch.read_data !== e.read_data)
                    begin
                        $error("read_data: expected %0h, actual %0h",
                               e.read_data, res_ch.read_data);
                        errs++;
                    end
                    if (res_ch.irq_level !== e.irq_level)
                    begin
                        $error("irq_level: expected %0b, actual %0b",
                               e.irq_level, res_ch.irq_level);
                        errs++;
                    end
                    if (res_ch.mixed_sample !== e.mixed_sample)
                    begin
                        $error("mixed_sample: expected %0d, actual %0d",
                               e.mixed_sample, res_ch.mixed_sample);
                        errs++;
                    end
                    if (res_ch.display_base !== e.display_base)
                    begin
                        $error("display_base: expected %0h, actual %0h",
                               e.display_base, res_ch.display_base);
                        errs++;
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                unit_results_q.push_back(predict_unit_result(cmd_ch.command,
                    cmd_ch.address, cmd_ch.write_data, cmd_ch.cycles));
            end
            fail_count <= fail_count + errs;
            outstanding <= unit_results_q.size();
        end
    end

endmodule

// ===== dv/linked_timer_and_lfsr_audio_unit_tb.sv =====
// ============================================================================
// linked_timer_and_lfsr_audio_unit_tb
// Drives bus reads, bus writes and ticks into the timer and audio unit with
// bursty input and a stalling result side. A directed opening covers the
// fixed registers, interrupts, cascades, the scanline latch and the LFSR; a
// random part follows. The checker predicts and compares every result beat.
// ============================================================================
module linked_timer_and_lfsr_audio_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ltla_pkg::*;

    localparam int RANDOM_BEATS = 950;
    localparam int IDLE_LIMIT   = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   burst_left;
    int   idle_cycles;

    ltla_cmd_if cmd_ch ();
    ltla_res_if res_ch ();

    linked_timer_and_lfsr_audio_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch.sink),
        .res_ch (res_ch.source)
    );

    ltla_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_ch      (cmd_ch),
        .res_ch      (res_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Result side stalls in phases: always ready, random, or long holds.
    always @(posedge clk or negedge rst_n)
    begin
        int phase_cnt;
        int mode;
        int hold;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            phase_cnt = 0;
            mode = 0;
            hold = 0;
        end
        else
        begin
            if (phase_cnt == 0)
            begin
                phase_cnt = $urandom_range(20, 120);
                mode = $urandom_range(0, 2);
            end
            phase_cnt--;
            case (mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (hold == 0)
                        hold = $urandom_range(1, 12);
                    hold--;
                    res_ch.ready <= (hold == 0);
                end
            endcase
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Send one beat; bursts end with a random gap before the next beat.
    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] addr,
                             input logic [7:0] wdata, input logic [7:0] cyc);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= cmd;
        cmd_ch.address    <= addr;
        cmd_ch.write_data <= wdata;
        cmd_ch.cycles     <= cyc;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic wr(input logic [7:0] addr, input logic [7:0] wdata);
        send_beat(CMD_WRITE, addr, wdata, 8'($urandom_range(0, 255)));
    endtask

    task automatic rd(input logic [7:0] addr);
        send_beat(CMD_READ, addr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic tick(input logic [7:0] cyc);
        send_beat(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), cyc);
    endtask

    // Hold the input side until every predicted result has come back.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Control byte: count enable usually set, everything else random.
    function automatic logic [7:0] random_ctl();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) != 0)
            v[3] = 1'b1;
        return v;
    endfunction

    task automatic random_beat();
        int kind;
        int sub;
        logic [7:0] addr;
        logic [7:0] v;
        kind = $urandom_range(0, 99);
        if (kind < 28)
        begin
            sub = $urandom_range(0, 3);
            addr = 8'(($urandom_range(0, TIMER_NUM - 1) << 2) | sub);
            v = (sub == 1) ? random_ctl() :
                ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 12));
            wr(addr, v);
        end
        else if (kind < 48)
        begin
            sub = $urandom_range(0, 7);
            addr = 8'(8'h20 + ($urandom_range(0, 3) << 3) + sub);
            v = (sub == 5) ? random_ctl() :
                (sub == 4 || sub == 6) ? 8'($urandom_range(0, 6))
                                       : 8'($urandom_range(0, 255));
            wr(addr, v);
        end
        else if (kind < 58)
        begin
            case ($urandom_range(0, 6))
                0: addr = ADDR_PEND_CLR;
                1: addr = ADDR_PEND_SET;
                2: addr = ADDR_DIR;
                3: addr = ADDR_PORT;
                4: addr = ADDR_DISP_LO;
                5: addr = ADDR_DISP_HI;
                default: addr = 8'($urandom_range(0, 255));
            endcase
            wr(addr, 8'($urandom_range(0, 255)));
        end
        else if (kind < 78)
        begin
            addr = ($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 8'h3f))
                                               : 8'($urandom_range(0, 255));
            rd(addr);
        end
        else
        begin
            tick(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        burst_left = 0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_READ;
        cmd_ch.address = '0;
        cmd_ch.write_data = '0;
        cmd_ch.cycles = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fixed offsets and the pending register.
        rd(ADDR_ZERO_A);
        rd(ADDR_ZERO_C);
        rd(ADDR_CONST_80);
        rd(ADDR_CONST_01);
        rd(ADDR_CONST_A0);
        wr(ADDR_PEND_SET, 8'hff);
        wr(ADDR_PEND_CLR, 8'h0f);
        rd(ADDR_PEND_SET);
        wr(ADDR_PEND_CLR, 8'hff);
        wr(ADDR_DIR, 8'hff);
        wr(ADDR_PORT, 8'hff);
        rd(ADDR_PORT);

        // Scanline latch: timer 0 expires with timer 2 linked at line 102.
        wr(ADDR_DISP_LO, 8'h34);
        wr(ADDR_DISP_HI, 8'hff);
        wr(8'h0a, LINE_LATCH);
        wr(8'h09, 8'h0f);
        wr(8'h01, 8'h98);
        tick(8'd4);

        // Audio channel 0 free-running; timer 4 with interrupts never flags.
        wr(8'h20, 8'h7f);
        wr(8'h21, 8'hff);
        wr(8'h27, 8'hf5);
        wr(8'h25, 8'h18);
        wr(8'h11, 8'h88);
        tick(8'd255);
        tick(8'd0);
        rd(8'h3f);
        drain();

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            random_beat();
            if (i == RANDOM_BEATS / 2)
                drain();
        end

        drain();
        repeat (1000) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
